>>> src/rtc_pkg.sv
// ----------------------------------------------------------------------------
// rtc_pkg
// shared constants for the rtc seconds counter register block
// ----------------------------------------------------------------------------
package rtc_pkg;

  // default size of the register region in bytes
  localparam int REGION_BYTES_DEF = 64;

  // item kinds
  localparam logic [1:0] FUNC_READ  = 2'd0;
  localparam logic [1:0] FUNC_WRITE = 2'd1;
  localparam logic [1:0] FUNC_TICK  = 2'd2;

  // access sizes
  localparam logic [1:0] SIZE_BYTE = 2'd0;
  localparam logic [1:0] SIZE_HALF = 2'd1;
  localparam logic [1:0] SIZE_WORD = 2'd2;

  // register byte offsets
  localparam logic [7:0] OFF_CTLRL = 8'h04;
  localparam logic [7:0] OFF_CNTH  = 8'h18;
  localparam logic [7:0] OFF_CNTL  = 8'h1C;
  localparam logic [7:0] OFF_ALRMH = 8'h20;
  localparam logic [7:0] OFF_ALRML = 8'h24;

  // control register flag bits
  localparam logic [15:0] FLAG_SECF  = 16'h0001;
  localparam logic [15:0] FLAG_ALRF  = 16'h0002;
  localparam logic [15:0] FLAG_RSF   = 16'h0008;
  localparam logic [15:0] FLAG_RTOFF = 16'h0020;

endpackage

>>> src/rtc_if.sv
// ----------------------------------------------------------------------------
// rtc_if
// valid/ready channels for bus requests and read results
// ----------------------------------------------------------------------------
interface rtc_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [7:0]  addr;
  logic [1:0]  access_size;
  logic [31:0] write_data;

  modport source (output valid, output func, output addr, output access_size,
                  output write_data, input ready);
  modport sink   (input valid, input func, input addr, input access_size,
                  input write_data, output ready);
endinterface

interface rtc_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] read_data;

  modport source (output valid, output read_data, input ready);
  modport sink   (input valid, input read_data, output ready);
endinterface

>>> src/rtc_seconds_counter_alarm_regs.sv
// ----------------------------------------------------------------------------
// rtc_seconds_counter_alarm_regs
// seconds counter with alarm behind a file of 16-bit shadow registers
// ----------------------------------------------------------------------------
// path: from request beat to result beat through the shadow ram read (stage 1)
//   and then the result register
// throughput: one beat per cycle without back-pressure, set by the shadow ram's
//   separate read and write ports with a bypass for a write to the row being read
// reset: synchronous active-low rst_n clears counter, alarm, running flag,
//   the row valid bits (unwritten rows read zero) and both pipeline valids
// ----------------------------------------------------------------------------
module rtc_seconds_counter_alarm_regs
  import rtc_pkg::*;
#(
  parameter int REGION_BYTES = REGION_BYTES_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  rtc_req_if.sink  in_bus,
  rtc_rsp_if.source out_bus
);

  // shadow halfwords held in pairs: one 32-bit row per aligned word
  localparam int DEPTH = (REGION_BYTES + 1) / 2;
  localparam int ROWS  = (DEPTH + 1) / 2;
  localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam logic [8:0] REGION_LIM = 9'(REGION_BYTES);

  // fixed rows of the named registers, each in the low half of its row
  localparam logic [5:0] ROW_CNTH  = OFF_CNTH[7:2];
  localparam logic [5:0] ROW_CNTL  = OFF_CNTL[7:2];
  localparam logic [5:0] ROW_ALRMH = OFF_ALRMH[7:2];
  localparam logic [5:0] ROW_ALRML = OFF_ALRML[7:2];

  // shadow ram and per-row valid bits
  logic [31:0]     mem_r [ROWS];
  logic [ROWS-1:0] row_vld_r;

  // stage 1: request register plus registered ram read
  logic        s1_vld_r;
  logic [1:0]  s1_func_r;
  logic [7:0]  s1_addr_r;
  logic [1:0]  s1_size_r;
  logic [31:0] s1_wdata_r;
  logic [31:0] rd_data_r;
  logic        rd_vld_r;
  logic        byp_r;
  logic [31:0] byp_data_r;

  // timer state and copies of the halfwords used for reloads
  logic [31:0] cnt_r, cnt_nxt;
  logic        run_r, run_nxt;
  logic [31:0] alarm_r, alarm_nxt;
  logic [15:0] cnth_r, cnth_nxt;
  logic [15:0] cntl_r, cntl_nxt;
  logic [15:0] alrmh_r, alrmh_nxt;
  logic [15:0] alrml_r, alrml_nxt;

  // result register
  logic        out_vld_r;
  logic [31:0] out_data_r;

  logic             s1_fire;
  logic             in_fire;
  logic [ROW_W-1:0] in_row;
  logic [ROW_W-1:0] s1_row;
  logic [31:0]      row_cur;
  logic [31:0]      row_new;
  logic             mem_we;
  logic [31:0]      rdata_nxt;

  // stage 1 moves on whenever the result slot is free or being drained
  assign s1_fire      = s1_vld_r && (!out_vld_r || out_bus.ready);
  assign in_bus.ready = !s1_vld_r || s1_fire;
  assign in_fire      = in_bus.valid && in_bus.ready;

  assign in_row = in_bus.addr[ROW_W+1:2];
  assign s1_row = s1_addr_r[ROW_W+1:2];

  // current row: bypassed write, ram data, or zero for a row never written
  assign row_cur = byp_r ? byp_data_r : (rd_vld_r ? rd_data_r : 32'd0);

  always_comb begin
    logic        in_region;
    logic        half_ok;
    logic        word_ok;
    logic [15:0] hv;
    logic [15:0] view;
    logic [15:0] ctlrl;
    logic        at_ctlrl;
    logic        at_cnth;
    logic        at_cntl;
    logic        at_alrmh;
    logic        at_alrml;
    logic [8:0]  word_end;

    in_region = {1'b0, s1_addr_r} < REGION_LIM;
    word_end  = {1'b0, s1_addr_r} + 9'd4;
    half_ok   = in_region && (s1_size_r == SIZE_HALF) && !s1_addr_r[0];
    word_ok   = in_region && (s1_size_r == SIZE_WORD) && (s1_addr_r[1:0] == 2'b00) &&
                (word_end <= REGION_LIM);
    at_ctlrl  = {s1_addr_r[7:1], 1'b0} == OFF_CTLRL;
    at_cnth   = {s1_addr_r[7:1], 1'b0} == OFF_CNTH;
    at_cntl   = {s1_addr_r[7:1], 1'b0} == OFF_CNTL;
    at_alrmh  = s1_addr_r == OFF_ALRMH;
    at_alrml  = s1_addr_r == OFF_ALRML;

    // halfword of the shadow at the even address
    hv = s1_addr_r[1] ? row_cur[31:16] : row_cur[15:0];

    // control register with live flags
    ctlrl = hv | FLAG_RTOFF | FLAG_RSF;
    if (run_r) begin
      ctlrl = ctlrl | FLAG_SECF;
      if ((alarm_r != 32'd0) && (cnt_r >= alarm_r)) begin
        ctlrl = ctlrl | FLAG_ALRF;
      end
    end

    // halfword view with live count applied
    if (at_ctlrl) begin
      view = ctlrl;
    end else if (run_r && at_cnth) begin
      view = cnt_r[31:16];
    end else if (run_r && at_cntl) begin
      view = cnt_r[15:0];
    end else begin
      view = hv;
    end

    rdata_nxt = 32'd0;
    row_new   = row_cur;
    mem_we    = 1'b0;
    cnt_nxt   = cnt_r;
    run_nxt   = run_r;
    alarm_nxt = alarm_r;

    case (s1_func_r)
      FUNC_READ: begin
        if (in_region && (s1_size_r == SIZE_BYTE)) begin
          rdata_nxt = {24'd0, s1_addr_r[0] ? view[15:8] : view[7:0]};
        end else if (half_ok) begin
          rdata_nxt = {16'd0, view};
        end else if (word_ok) begin
          if (s1_addr_r == OFF_CTLRL) begin
            rdata_nxt = {row_cur[31:16], ctlrl};
          end else if (run_r && (s1_addr_r == OFF_CNTH)) begin
            rdata_nxt = cnt_r;
          end else begin
            rdata_nxt = row_cur;
          end
        end
      end
      FUNC_WRITE: begin
        if (in_region && (s1_size_r == SIZE_BYTE)) begin
          mem_we = 1'b1;
          row_new[8*s1_addr_r[1:0] +: 8] = s1_wdata_r[7:0];
        end else if (half_ok) begin
          mem_we = 1'b1;
          row_new[16*s1_addr_r[1] +: 16] = s1_wdata_r[15:0];
        end else if (word_ok) begin
          mem_we  = 1'b1;
          row_new = s1_wdata_r;
        end
      end
      FUNC_TICK: begin
        if (run_r) begin
          cnt_nxt = cnt_r + 32'd1;
        end
      end
      default: begin
      end
    endcase

    // keep the reload copies in step with the shadow
    cnth_nxt  = (mem_we && (s1_addr_r[7:2] == ROW_CNTH))  ? row_new[15:0] : cnth_r;
    cntl_nxt  = (mem_we && (s1_addr_r[7:2] == ROW_CNTL))  ? row_new[15:0] : cntl_r;
    alrmh_nxt = (mem_we && (s1_addr_r[7:2] == ROW_ALRMH)) ? row_new[15:0] : alrmh_r;
    alrml_nxt = (mem_we && (s1_addr_r[7:2] == ROW_ALRML)) ? row_new[15:0] : alrml_r;

    // counter and alarm loads
    if (s1_func_r == FUNC_WRITE) begin
      if (half_ok && (at_cnth || at_cntl)) begin
        cnt_nxt = {cnth_nxt, cntl_nxt};
        run_nxt = 1'b1;
      end
      if (half_ok && (at_alrmh || at_alrml)) begin
        alarm_nxt = {alrmh_nxt, alrml_nxt};
      end
      if (word_ok && (s1_addr_r == OFF_CNTH)) begin
        cnt_nxt = s1_wdata_r;
        run_nxt = 1'b1;
      end
      if (word_ok && at_alrmh) begin
        alarm_nxt = s1_wdata_r;
      end
    end
  end

  // shadow ram: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (s1_fire && mem_we) begin
      mem_r[s1_row] <= row_new;
    end
    if (in_fire) begin
      rd_data_r <= mem_r[in_row];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_vld_r <= '0;
      rd_vld_r  <= 1'b0;
      byp_r     <= 1'b0;
    end else begin
      if (s1_fire && mem_we) begin
        row_vld_r[s1_row] <= 1'b1;
      end
      if (in_fire) begin
        rd_vld_r <= row_vld_r[in_row];
        // same-edge write to the row being read
        byp_r    <= s1_fire && mem_we && (s1_row == in_row);
      end
    end
  end

  // request payload and bypass data
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_func_r  <= in_bus.func;
      s1_addr_r  <= in_bus.addr;
      s1_size_r  <= in_bus.access_size;
      s1_wdata_r <= in_bus.write_data;
      byp_data_r <= row_new;
    end
  end

  // timer state, copies and pipeline valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      cnt_r     <= 32'd0;
      run_r     <= 1'b0;
      alarm_r   <= 32'd0;
      cnth_r    <= 16'd0;
      cntl_r    <= 16'd0;
      alrmh_r   <= 16'd0;
      alrml_r   <= 16'd0;
    end else begin
      if (in_fire) begin
        s1_vld_r <= 1'b1;
      end else if (s1_fire) begin
        s1_vld_r <= 1'b0;
      end
      if (s1_fire) begin
        out_vld_r <= 1'b1;
        cnt_r     <= cnt_nxt;
        run_r     <= run_nxt;
        alarm_r   <= alarm_nxt;
        cnth_r    <= cnth_nxt;
        cntl_r    <= cntl_nxt;
        alrmh_r   <= alrmh_nxt;
        alrml_r   <= alrml_nxt;
      end else if (out_bus.ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_data_r <= rdata_nxt;
    end
  end

  assign out_bus.valid     = out_vld_r;
  assign out_bus.read_data = out_data_r;

endmodule

>>> test/rtc_seconds_counter_alarm_regs_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtc_seconds_counter_alarm_regs_tb
// self-checking bench for the seconds counter and alarm register block
// ----------------------------------------------------------------------------
// a short scripted sequence covers reset values, counter load and wrap, alarm
// flags, byte/halfword/word views and rejected accesses. Random bus traffic
// follows in four phases of sender idling and receiver back-pressure. Every
// request beat updates a local mirror of the register file, and each result
// beat is compared with the oldest predicted read data.
// ----------------------------------------------------------------------------
module rtc_seconds_counter_alarm_regs_tb;
  import rtc_pkg::*;

  localparam int REGION       = REGION_BYTES_DEF;
  localparam int SHADOW_DEPTH = (REGION + 1) / 2;
  localparam int HW_BITS      = $clog2(SHADOW_DEPTH);
  localparam int N_DIRECTED   = 25;
  localparam int RANDOM_PER_PHASE = 145;
  localparam int MAX_REPORTS  = 10;

  // codes the package leaves unnamed
  localparam logic [1:0] FUNC_NONE = 2'd3;
  localparam logic [1:0] SIZE_BAD  = 2'd3;

  typedef struct packed {
    logic [1:0]  func;
    logic [7:0]  addr;
    logic [1:0]  size;
    logic [31:0] data;
  } bus_req_t;

  // scripted row: request plus an optional hand-written read result
  typedef struct packed {
    bus_req_t    req;
    logic        known;
    logic [31:0] rd;
  } script_row_t;

  logic clk = 1'b0;
  logic rst_n;

  rtc_req_if req_ch ();
  rtc_rsp_if rsp_ch ();

  rtc_seconds_counter_alarm_regs i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_bus (req_ch),
    .out_bus(rsp_ch)
  );

  always #1 clk = ~clk;

  // mirror of the block state
  logic [15:0] mirror_half [SHADOW_DEPTH];
  logic [31:0] mirror_count;
  logic [31:0] mirror_alarm;
  logic        mirror_run;

  // predicted read data, oldest first
  logic [31:0] read_data_due [$];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int mismatch_count = 0;
  int results_seen   = 0;
  int reads_sent     = 0;
  int writes_sent    = 0;
  int ticks_sent     = 0;
  int other_sent     = 0;
  int alarm_flags    = 0;
  int count_wraps    = 0;

  // scripted sequence, typed results only where obvious
  script_row_t directed_rows [N_DIRECTED] = '{
    // reset values: control reads rtoff|rsf, stopped counter shows shadow
    '{'{FUNC_READ,  OFF_CTLRL, SIZE_WORD, 32'h0},           1'b1, 32'h0000_0028},
    '{'{FUNC_READ,  OFF_CNTH,  SIZE_HALF, 32'h0},           1'b1, 32'h0},
    // beyond the region
    '{'{FUNC_READ,  8'hFF,     SIZE_BYTE, 32'h0},           1'b1, 32'h0},
    // load near the top, then tick through the wrap
    '{'{FUNC_WRITE, OFF_CNTH,  SIZE_WORD, 32'hFFFF_FFFE},   1'b1, 32'h0},
    '{'{FUNC_READ,  OFF_CNTH,  SIZE_WORD, 32'h0},           1'b1, 32'hFFFF_FFFE},
    '{'{FUNC_TICK,  8'h00,     SIZE_BYTE, 32'h0},           1'b1, 32'h0},
    '{'{FUNC_READ,  OFF_CNTH,  SIZE_WORD, 32'h0},           1'b1, 32'hFFFF_FFFF},
    '{'{FUNC_TICK,  8'hFF,     SIZE_BAD,  32'hFFFF_FFFF},   1'b1, 32'h0},
    '{'{FUNC_READ,  OFF_CNTL,  SIZE_HALF, 32'h0},           1'b1, 32'h0},
    // alarm from the two halves, not yet reached
    '{'{FUNC_WRITE, OFF_ALRML, SIZE_HALF, 32'h1234_0003},   1'b1, 32'h0},
    '{'{FUNC_READ,  OFF_CTLRL, SIZE_HALF, 32'h0},           1'b1, 32'h0000_0029},
    // count past the alarm
    '{'{FUNC_WRITE, OFF_CNTH,  SIZE_WORD, 32'h0000_0005},   1'b1, 32'h0},
    '{'{FUNC_READ,  OFF_CTLRL, SIZE_HALF, 32'h0},           1'b1, 32'h0000_002B},
    // largest alarm clears the flag again
    '{'{FUNC_WRITE, OFF_ALRMH, SIZE_WORD, 32'hFFFF_FFFF},   1'b1, 32'h0},
    // byte write into the control shadow, then byte view of the alarm
    '{'{FUNC_WRITE, 8'h05,     SIZE_BYTE, 32'hFFFF_FFA5},   1'b1, 32'h0},
    '{'{FUNC_READ,  OFF_CTLRL, SIZE_HALF, 32'h0},           1'b0, 32'h0},
    '{'{FUNC_READ,  8'h25,     SIZE_BYTE, 32'h0},           1'b0, 32'h0},
    // word write at the low count only fills the shadow
    '{'{FUNC_WRITE, OFF_CNTL,  SIZE_WORD, 32'hDEAD_BEEF},   1'b1, 32'h0},
    '{'{FUNC_READ,  OFF_CNTL,  SIZE_WORD, 32'h0},           1'b0, 32'h0},
    // halfword write reloads the counter from both shadows
    '{'{FUNC_WRITE, OFF_CNTH,  SIZE_HALF, 32'h0000_0001},   1'b1, 32'h0},
    // last word in the region, then rejected accesses
    '{'{FUNC_READ,  8'h3C,     SIZE_WORD, 32'h0},           1'b0, 32'h0},
    '{'{FUNC_READ,  8'h3E,     SIZE_WORD, 32'h0},           1'b1, 32'h0},
    '{'{FUNC_READ,  8'h02,     SIZE_BAD,  32'h0},           1'b1, 32'h0},
    '{'{FUNC_NONE,  OFF_CTLRL, SIZE_WORD, 32'h0},           1'b1, 32'h0},
    '{'{FUNC_WRITE, 8'h40,     SIZE_HALF, 32'hFFFF_FFFF},   1'b1, 32'h0}
  };

  // halfword slot of an in-region byte offset
  function automatic logic [HW_BITS-1:0] hw_idx(logic [7:0] a);
    return a[HW_BITS:1];
  endfunction

  // control register as seen on a read
  function automatic logic [15:0] control_view();
    logic [15:0] v;
    v = mirror_half[hw_idx(OFF_CTLRL)] | FLAG_RTOFF | FLAG_RSF;
    if (mirror_run) begin
      v |= FLAG_SECF;
      if (mirror_alarm != 0 && mirror_count >= mirror_alarm) v |= FLAG_ALRF;
    end
    return v;
  endfunction

  // halfword at an even in-region offset, live values applied
  function automatic logic [15:0] half_view(logic [7:0] a);
    if (a == OFF_CTLRL) return control_view();
    if (mirror_run && a == OFF_CNTH) return mirror_count[31:16];
    if (mirror_run && a == OFF_CNTL) return mirror_count[15:0];
    return mirror_half[hw_idx(a)];
  endfunction

  // applies one request to the mirror and returns the read data it yields
  function automatic logic [31:0] predict_read_data(bus_req_t r);
    logic [31:0] rd;
    logic [15:0] hv;
    logic [15:0] lo;
    logic [7:0]  a;
    logic        in_region;
    logic        word_ok;
    rd = '0;
    a  = r.addr;
    in_region = int'(a) < REGION;
    word_ok   = (a[1:0] == 2'b00) && (int'(a) + 4 <= REGION);
    case (r.func)
      FUNC_READ: begin
        if (!in_region) begin
          rd = '0;
        end else if (r.size == SIZE_HALF && !a[0]) begin
          rd = {16'd0, half_view(a)};
        end else if (r.size == SIZE_BYTE) begin
          hv = half_view({a[7:1], 1'b0});
          rd = {24'd0, a[0] ? hv[15:8] : hv[7:0]};
        end else if (r.size == SIZE_WORD && word_ok) begin
          if (mirror_run && a == OFF_CNTH) begin
            rd = mirror_count;
          end else begin
            // word at the low count takes its low half from the shadow
            lo = (a == OFF_CTLRL) ? control_view() : mirror_half[hw_idx(a)];
            rd = {mirror_half[hw_idx(a + 8'd2)], lo};
          end
        end
        if (a == OFF_CTLRL && rd[1] && r.size != SIZE_BAD)
          alarm_flags++;
      end
      FUNC_WRITE: begin
        if (!in_region) begin
          // ignored
        end else if (r.size == SIZE_HALF && !a[0]) begin
          mirror_half[hw_idx(a)] = r.data[15:0];
          if (a == OFF_CNTH || a == OFF_CNTL) begin
            mirror_count = {mirror_half[hw_idx(OFF_CNTH)], mirror_half[hw_idx(OFF_CNTL)]};
            mirror_run   = 1'b1;
          end
          if (a == OFF_ALRMH || a == OFF_ALRML)
            mirror_alarm = {mirror_half[hw_idx(OFF_ALRMH)], mirror_half[hw_idx(OFF_ALRML)]};
        end else if (r.size == SIZE_BYTE) begin
          if (a[0]) mirror_half[hw_idx(a)][15:8] = r.data[7:0];
          else      mirror_half[hw_idx(a)][7:0]  = r.data[7:0];
        end else if (r.size == SIZE_WORD && word_ok) begin
          mirror_half[hw_idx(a)]         = r.data[15:0];
          mirror_half[hw_idx(a + 8'd2)]  = r.data[31:16];
          if (a == OFF_CNTH) begin
            mirror_count = r.data;
            mirror_run   = 1'b1;
          end
          if (a == OFF_ALRMH) mirror_alarm = r.data;
        end
      end
      FUNC_TICK: begin
        if (mirror_run) begin
          if (mirror_count == 32'hFFFF_FFFF) count_wraps++;
          mirror_count = mirror_count + 32'd1;
        end
      end
      default: ;
    endcase
    return rd;
  endfunction

  // one request beat: optional idle gap, hold until ready, then predict
  task automatic drive_beat(bus_req_t r, logic known, logic [31:0] typed);
    logic [31:0] rd;
    while ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid       <= 1'b1;
    req_ch.func        <= r.func;
    req_ch.addr        <= r.addr;
    req_ch.access_size <= r.size;
    req_ch.write_data  <= r.data;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    rd = predict_read_data(r);
    read_data_due.push_back(known ? typed : rd);
    case (r.func)
      FUNC_READ:  reads_sent++;
      FUNC_WRITE: writes_sent++;
      FUNC_TICK:  ticks_sent++;
      default:    other_sent++;
    endcase
  endtask

  // sender holds off until every predicted result has come back
  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (read_data_due.size() != 0) @(posedge clk);
  endtask

  // result side: random back-pressure and comparison
  always @(posedge clk) begin
    if (rst_n) begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        results_seen++;
        if (read_data_due.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("%0t: result beat with nothing pending, read_data %08h",
                     $realtime, rsp_ch.read_data);
        end else begin
          logic [31:0] want;
          want = read_data_due.pop_front();
          if (rsp_ch.read_data !== want) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
              $display("%0t: read_data mismatch, expected %08h got %08h",
                       $realtime, want, rsp_ch.read_data);
          end
        end
      end
      rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end else begin
      rsp_ch.ready <= 1'b0;
    end
  end

  // hard stop well beyond the slowest legal run
  initial begin
    #400_000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    int       idle_plan  [4] = '{0, 68, 0, 8};
    int       stall_plan [4] = '{0, 0, 68, 8};
    bus_req_t r;
    int       pick;
    logic [7:0] reg_offs [5] = '{OFF_CTLRL, OFF_CNTH, OFF_CNTL, OFF_ALRMH, OFF_ALRML};

    // quiet bus and reset state of the mirror
    rst_n              <= 1'b0;
    req_ch.valid       <= 1'b0;
    req_ch.func        <= FUNC_READ;
    req_ch.addr        <= '0;
    req_ch.access_size <= SIZE_BYTE;
    req_ch.write_data  <= '0;
    for (int i = 0; i < SHADOW_DEPTH; i++) mirror_half[i] = '0;
    mirror_count = '0;
    mirror_alarm = '0;
    mirror_run   = 1'b0;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // scripted part with no idling
    for (int i = 0; i < N_DIRECTED; i++)
      drive_beat(directed_rows[i].req, directed_rows[i].known, directed_rows[i].rd);
    wait_drained();

    // random traffic, one phase per idling profile
    for (int p = 0; p < 4; p++) begin
      send_idle_pct  = idle_plan[p];
      recv_stall_pct = stall_plan[p];
      repeat (RANDOM_PER_PHASE) begin
        pick = $urandom_range(99);
        r.func = (pick < 34) ? FUNC_READ : (pick < 68) ? FUNC_WRITE :
                 (pick < 93) ? FUNC_TICK : FUNC_NONE;
        // mostly the live registers and their neighbours
        pick = $urandom_range(9);
        if (pick < 5) begin
          r.addr = reg_offs[pick];
          if ($urandom_range(4) == 0) r.addr = r.addr + 8'($urandom_range(3));
        end else if (pick < 9) begin
          r.addr = 8'($urandom_range(REGION - 1));
        end else begin
          r.addr = 8'($urandom_range(255));
        end
        pick = $urandom_range(9);
        r.size = (pick < 3) ? SIZE_HALF : (pick < 6) ? SIZE_WORD :
                 (pick < 9) ? SIZE_BYTE : SIZE_BAD;
        // small values make the alarm reachable, high ones force wraps
        pick = $urandom_range(7);
        if (pick < 2)       r.data = 32'($urandom_range(15));
        else if (pick == 2) r.data = 32'hFFFF_FFF0 | 32'($urandom_range(15));
        else                r.data = $urandom;
        drive_beat(r, 1'b0, 32'h0);
      end
      wait_drained();
    end

    // let any stray beat show up
    recv_stall_pct = 0;
    repeat (8) @(posedge clk);

    $display("sent %0d reads, %0d writes, %0d ticks, %0d no-ops; %0d results checked",
             reads_sent, writes_sent, ticks_sent, other_sent, results_seen);
    $display("alarm flag seen on %0d control reads, counter wrapped %0d times, %0d mismatches",
             alarm_flags, count_wraps, mismatch_count);
    if (mismatch_count == 0 && read_data_due.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
